// ----- hw/rtl/sorted_set_table_assert.svh -----
// Assertion macros for the sorted set table checker.
// Each macro expects clk and arst_n to be visible in the calling scope.
`ifndef SORTED_SET_TABLE_ASSERT_SVH
`define SORTED_SET_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define SST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/sst_pkg.sv -----
// Shared types and constants for the sorted set table.
// No dependencies; used by sst_cell, sorted_set_table and sst_checker.
`timescale 1ns / 1ps

package sst_pkg;

	localparam int SST_CAPACITY = 64;
	localparam int SST_DATA_W   = 32;

	// Action codes carried on the input channel
	typedef enum logic [2:0] {
		ACT_INSERT = 3'd0,
		ACT_REMOVE = 3'd1,
		ACT_SEARCH = 3'd2,
		ACT_CLEAR  = 3'd3,
		ACT_FIRST  = 3'd4,
		ACT_NEXT   = 3'd5
	} action_t;

	// What a token does in the cell it reaches
	typedef enum logic [2:0] {
		MODE_NOP  = 3'd0, // pass through untouched
		MODE_INS  = 3'd1, // look for the insert slot
		MODE_SHR  = 3'd2, // push carried value in, carry old one right
		MODE_REM  = 3'd3, // look for the value to delete
		MODE_SHL  = 3'd4, // hole travels right, left neighbor pulls
		MODE_SRCH = 3'd5, // membership test only
		MODE_CLR  = 3'd6, // invalidate every cell on the way
		MODE_READ = 3'd7  // pick up the value at one index
	} mode_t;

	// Token that walks the chain, one cell per cycle
	typedef struct packed {
		logic                         vld;
		mode_t                        mode;
		logic signed [SST_DATA_W-1:0] key;
		logic                         hit;
		logic                         dup;
	} pkt_t;

endpackage

// ----- hw/rtl/sst_cell.sv -----
// One cell of the sorted chain: holds a single entry and processes the token.
// Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_cell #(
	parameter int IDX_W = 6,
	parameter int INDEX = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sst_pkg::pkt_t                        pkt_in,
	input  logic [IDX_W-1:0]                     pos_in,
	output sst_pkg::pkt_t                        pkt_q,
	output logic [IDX_W-1:0]                     pos_q,
	input  logic signed [sst_pkg::SST_DATA_W-1:0] right_val,
	input  logic                                 right_vld,
	output logic signed [sst_pkg::SST_DATA_W-1:0] val_q,
	output logic                                 vld_q
);
	import sst_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	pkt_t                        pkt_d;
	logic [IDX_W-1:0]            pos_d;
	logic signed [SST_DATA_W-1:0] val_d;
	logic                        vld_d;
	logic                        is_lt;
	logic                        is_eq;

	assign is_lt = vld_q && ($signed(val_q) < $signed(pkt_in.key));
	assign is_eq = vld_q && (val_q == pkt_in.key);

	// Token handling and entry update
	always_comb begin
		pkt_d = pkt_in;
		pos_d = pos_in;
		val_d = val_q;
		vld_d = vld_q;
		// a hole left behind by our own token: pull the right neighbor in
		if (pkt_q.vld && pkt_q.mode == MODE_SHL) begin
			val_d = right_val;
			vld_d = right_vld;
		end
		if (pkt_in.vld) begin
			case (pkt_in.mode)
				MODE_INS: begin
					if (is_eq) begin
						pkt_d.dup  = 1'b1;
						pkt_d.mode = MODE_NOP;
					end else if (!is_lt) begin
						val_d     = pkt_in.key;
						vld_d     = 1'b1;
						pkt_d.hit = 1'b1;
						pos_d     = MY_IDX;
						pkt_d.key = val_q;
						pkt_d.mode = vld_q ? MODE_SHR : MODE_NOP;
					end
				end
				MODE_SHR: begin
					val_d     = pkt_in.key;
					vld_d     = 1'b1;
					pkt_d.key = val_q;
					if (!vld_q) begin
						pkt_d.mode = MODE_NOP;
					end
				end
				MODE_REM: begin
					if (is_eq) begin
						pkt_d.hit  = 1'b1;
						pos_d      = MY_IDX;
						pkt_d.mode = MODE_SHL;
					end else if (!is_lt) begin
						pkt_d.mode = MODE_NOP;
					end
				end
				MODE_SRCH: begin
					if (is_eq) begin
						pkt_d.hit  = 1'b1;
						pkt_d.mode = MODE_NOP;
					end else if (!is_lt) begin
						pkt_d.mode = MODE_NOP;
					end
				end
				MODE_CLR: begin
					vld_d = 1'b0;
				end
				MODE_READ: begin
					if (pos_in == MY_IDX) begin
						pkt_d.key  = val_q;
						pkt_d.hit  = 1'b1;
						pkt_d.mode = MODE_NOP;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Control: entry valid and token valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			pkt_q <= '0;
		end else begin
			vld_q <= vld_d;
			pkt_q <= pkt_d;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		val_q <= val_d;
		pos_q <= pos_d;
	end

endmodule

// ----- hw/rtl/sorted_set_table.sv -----
// Sorted set table: a set of distinct signed 32-bit values kept in ascending order.
// Depends on sst_pkg and sst_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) carries action and item_value; output
//   channel (out_valid/out_ready) returns success, out_value and table_full,
//   exactly one result per input transfer.
//   Entries live in a chain of CAPACITY cells. Each operation launches a token
//   that moves one cell per cycle from the smallest entry to the largest;
//   inserts shift larger entries right behind it, removes pull them left.
//   The result is registered in a holding register when the token leaves
//   the chain, then moved to the output register. No new operation is taken
//   before the token has left; in_ready is high only while no token is in flight.
//   A finished result sits in the output register while the next operation is
//   accepted; if the receiver stalls, a second result waits in a holding
//   register and in_ready stays low until the output register frees up.
//   Reset empties the table, parks the traversal cursor past the end and
//   drops any pending result. Entry storage itself is not cleared.
`timescale 1ns / 1ps

module sorted_set_table #(
	parameter int CAPACITY = sst_pkg::SST_CAPACITY
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [2:0]                           action,
	input  logic signed [sst_pkg::SST_DATA_W-1:0] item_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 success,
	output logic signed [sst_pkg::SST_DATA_W-1:0] out_value,
	output logic                                 table_full
);
	import sst_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	state_t                       state_q;
	action_t                      act_q;
	logic                         full_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             walk_q;
	pkt_t                         launch_q;
	logic [IDX_W-1:0]             launch_pos_q;
	logic                         res_success_q;
	logic signed [SST_DATA_W-1:0] res_value_q;
	logic                         res_full_q;
	logic                         out_valid_q;
	logic                         success_q;
	logic signed [SST_DATA_W-1:0] out_value_q;
	logic                         table_full_q;

	pkt_t                         pkt_chain [0:CAPACITY];
	logic [IDX_W-1:0]             pos_chain [0:CAPACITY];
	logic signed [SST_DATA_W-1:0] cell_val  [0:CAPACITY-1];
	logic                         cell_vld  [0:CAPACITY-1];

	pkt_t                         launch_d;
	logic [IDX_W-1:0]             launch_pos_d;
	pkt_t                         exit_pkt;
	logic [CNT_W-1:0]             exit_pos;
	logic                         r_success;
	logic signed [SST_DATA_W-1:0] r_value;
	logic                         r_full;
	logic [CNT_W-1:0]             count_d;
	logic [CNT_W-1:0]             walk_d;
	logic                         is_full;

	// Chain of cells
	assign pkt_chain[0] = launch_q;
	assign pos_chain[0] = launch_pos_q;

	for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
		logic signed [SST_DATA_W-1:0] rv;
		logic                         rvld;
		if (gi == CAPACITY - 1) begin : g_last
			assign rv   = '0;
			assign rvld = 1'b0;
		end else begin : g_mid
			assign rv   = cell_val[gi+1];
			assign rvld = cell_vld[gi+1];
		end
		sst_cell #(
			.IDX_W (IDX_W),
			.INDEX (gi)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.pkt_in    (pkt_chain[gi]),
			.pos_in    (pos_chain[gi]),
			.pkt_q     (pkt_chain[gi+1]),
			.pos_q     (pos_chain[gi+1]),
			.right_val (rv),
			.right_vld (rvld),
			.val_q     (cell_val[gi]),
			.vld_q     (cell_vld[gi])
		);
	end

	assign exit_pkt = pkt_chain[CAPACITY];
	assign exit_pos = CNT_W'(pos_chain[CAPACITY]);
	assign is_full  = (count_q == CAP_CNT);

	// Token to launch for the incoming action
	always_comb begin
		launch_d      = '0;
		launch_d.vld  = 1'b1;
		launch_d.mode = MODE_NOP;
		launch_d.key  = item_value;
		launch_pos_d  = '0;
		case (action)
			ACT_INSERT: launch_d.mode = is_full ? MODE_SRCH : MODE_INS;
			ACT_REMOVE: launch_d.mode = MODE_REM;
			ACT_SEARCH: launch_d.mode = MODE_SRCH;
			ACT_CLEAR:  launch_d.mode = MODE_CLR;
			ACT_FIRST: begin
				if (count_q != '0) begin
					launch_d.mode = MODE_READ;
				end
			end
			ACT_NEXT: begin
				if (walk_q < count_q) begin
					launch_d.mode = MODE_READ;
					launch_pos_d  = walk_q[IDX_W-1:0];
				end
			end
			default: launch_d.mode = MODE_NOP;
		endcase
	end

	// Result and bookkeeping once the token leaves the chain
	always_comb begin
		r_success = 1'b0;
		r_value   = '0;
		r_full    = 1'b0;
		count_d   = count_q;
		walk_d    = walk_q;
		case (act_q)
			ACT_INSERT: begin
				if (full_q) begin
					r_full = !exit_pkt.hit;
				end else if (exit_pkt.hit) begin
					r_success = 1'b1;
					count_d   = count_q + 1'b1;
					if (exit_pos <= walk_q) begin
						walk_d = walk_q + 1'b1;
					end
				end
			end
			ACT_REMOVE: begin
				if (exit_pkt.hit) begin
					r_success = 1'b1;
					count_d   = count_q - 1'b1;
					if (exit_pos < walk_q) begin
						walk_d = walk_q - 1'b1;
					end
				end
			end
			ACT_SEARCH: r_success = exit_pkt.hit;
			ACT_CLEAR: begin
				count_d = '0;
				walk_d  = '0;
			end
			ACT_FIRST: begin
				if (exit_pkt.hit) begin
					r_success = 1'b1;
					r_value   = exit_pkt.key;
					walk_d    = CNT_W'(1);
				end
			end
			ACT_NEXT: begin
				if (exit_pkt.hit) begin
					r_success = 1'b1;
					r_value   = exit_pkt.key;
					walk_d    = walk_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, table bookkeeping and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			act_q         <= ACT_SEARCH;
			full_q        <= 1'b0;
			count_q       <= '0;
			walk_q        <= '0;
			launch_q      <= '0;
			launch_pos_q  <= '0;
			res_success_q <= 1'b0;
			res_value_q   <= '0;
			res_full_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			success_q     <= 1'b0;
			out_value_q   <= '0;
			table_full_q  <= 1'b0;
		end else begin
			// token lives in the launch register for one cycle only
			if (!(state_q == S_IDLE && in_valid)) begin
				launch_q.vld <= 1'b0;
			end
			// S_DONE decides out_valid on its own
			if (out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						launch_q     <= launch_d;
						launch_pos_q <= launch_pos_d;
						act_q        <= action_t'(action);
						full_q       <= is_full;
						state_q      <= S_RUN;
					end
				end
				S_RUN: begin
					if (exit_pkt.vld) begin
						res_success_q <= r_success;
						res_value_q   <= r_value;
						res_full_q    <= r_full;
						count_q       <= count_d;
						walk_q        <= walk_d;
						state_q       <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						success_q    <= res_success_q;
						out_value_q  <= res_value_q;
						table_full_q <= res_full_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign success    = success_q;
	assign out_value  = out_value_q;
	assign table_full = table_full_q;

endmodule

// ----- hw/rtl/sst_checker.sv -----
// Port-level checker for sorted_set_table, attached by the bind below.
// Depends on sorted_set_table_assert.svh and sst_pkg.
`timescale 1ns / 1ps
`include "sorted_set_table_assert.svh"

module sst_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic [2:0]                           action,
	input logic signed [sst_pkg::SST_DATA_W-1:0] item_value,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic                                 success,
	input logic signed [sst_pkg::SST_DATA_W-1:0] out_value,
	input logic                                 table_full
);
	// a stalled result keeps its payload
	`SST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(success) && $stable(table_full), "result changed while stalled")
	// a refused insert never reports success
	`SST_ASSERT_NOW(a_full_excl, out_valid && table_full, !success, "table_full with success")
	// a returned value is only ever a valid traversal value
	`SST_ASSERT_NOW(a_value_ok, out_valid && (out_value != 0), success, "nonzero value without success")
	// one operation in flight: no transfer in the cycle after one
	`SST_ASSERT_NEXT(a_one_op, in_valid && in_ready, !in_ready, "input taken back to back")

endmodule

bind sorted_set_table sst_checker u_sst_checker (.*);
